>>> hw/rtl/glt_pkg.sv
`timescale 1ns / 1ps

package glt_pkg;

    localparam int NODE_W            = 6;
    localparam int LABEL_W           = 6;
    localparam int COUNT_W           = 7;
    localparam int NUM_LABELS        = 1 << LABEL_W;
    localparam int MAX_NODES_DEFAULT = 64;

    localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 7'd64;

    localparam logic MODE_ASSIGN = 1'b0;
    localparam logic MODE_EXPORT = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic label_wr;     // write input label into the node table
        logic start;        // begin export: clear seen bits, fresh counter, walk index
        logic label_rd;     // fetch the node table entry at the walk index
        logic map_miss;     // first sighting: allocate fresh label
        logic map_rd;       // fetch the stored renumbered label
        logic out_load_map; // load output label from the rename read
        logic walk_inc;     // advance to the next node
    } glt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic assign_ok;    // input node is below the effective count
        logic count_zero;   // effective count is zero
        logic hit;          // group already seen in this export
        logic last;         // walk index is the final node
    } glt_status_t;

endpackage

>>> hw/rtl/group_label_table_relabel_core.sv
`timescale 1ns / 1ps
// assign word: taken while idle, no result word
// export word: per node a node table read, a seen check, a rename table read only when its
// group is already seen (both reads are registered memory ports), then emit until out_ready
// during an export no input word is taken until the last result leaves
// reset (async, active low) clears the controller, seen bits, fresh counter and node_count = 64
// node and rename tables are not cleared

module group_label_table_relabel_core #(
    parameter int MAX_NODES = glt_pkg::MAX_NODES_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration: node_count
    input  logic                          cfg_wr_en,
    input  logic [glt_pkg::COUNT_W-1:0]   cfg_wr_data,
    // input word
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          mode,
    input  logic [glt_pkg::NODE_W-1:0]    node,
    input  logic [glt_pkg::LABEL_W-1:0]   label,
    // result word
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [glt_pkg::NODE_W-1:0]    out_node,
    output logic [glt_pkg::LABEL_W-1:0]   new_label,
    output logic                          last
);
    import glt_pkg::*;

    glt_cmd_t    cmd;
    glt_status_t status;

    // sequencer: idle, table read, seen check, rename read, emit
    glt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // tables, seen bits, fresh label counter, walk index and output register
    glt_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .node        (node),
        .label       (label),
        .cmd         (cmd),
        .status      (status),
        .out_node    (out_node),
        .new_label   (new_label)
    );

    // last flag follows the walk index, which holds while the result word waits
    assign last = status.last;

endmodule

>>> hw/rtl/glt_datapath.sv
`timescale 1ns / 1ps

module glt_datapath #(
    parameter int MAX_NODES = glt_pkg::MAX_NODES_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [glt_pkg::COUNT_W-1:0]   cfg_wr_data,
    input  logic [glt_pkg::NODE_W-1:0]    node,
    input  logic [glt_pkg::LABEL_W-1:0]   label,
    input  glt_pkg::glt_cmd_t             cmd,
    output glt_pkg::glt_status_t          status,
    output logic [glt_pkg::NODE_W-1:0]    out_node,
    output logic [glt_pkg::LABEL_W-1:0]   new_label
);
    import glt_pkg::*;

    localparam int IDX_W = $clog2(MAX_NODES);
    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_NODES);

    logic [LABEL_W-1:0]    label_mem [MAX_NODES];
    logic [LABEL_W-1:0]    map_mem   [NUM_LABELS];

    logic [COUNT_W-1:0]    node_count_reg;
    logic [COUNT_W-1:0]    eff_count;
    logic [NODE_W-1:0]     walk_reg;
    logic [NODE_W-1:0]     walk_next;
    logic [LABEL_W-1:0]    fresh_reg;
    logic [LABEL_W-1:0]    fresh_next;
    logic [NUM_LABELS-1:0] seen_reg;
    logic [NUM_LABELS-1:0] seen_next;
    logic [LABEL_W-1:0]    label_q;
    logic [LABEL_W-1:0]    map_q;
    logic [LABEL_W-1:0]    out_label_reg;

    assign eff_count = (node_count_reg > MAX_COUNT) ? MAX_COUNT : node_count_reg;

    always_comb
    begin
        walk_next  = walk_reg;
        fresh_next = fresh_reg;
        seen_next  = seen_reg;
        if (cmd.start)
        begin
            walk_next  = '0;
            fresh_next = '0;
            seen_next  = '0;
        end
        else
        begin
            if (cmd.walk_inc)
            begin
                walk_next = walk_reg + NODE_W'(1);
            end
            if (cmd.map_miss)
            begin
                fresh_next         = fresh_reg + LABEL_W'(1);
                seen_next[label_q] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RESET;
            walk_reg       <= '0;
            fresh_reg      <= '0;
            seen_reg       <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                node_count_reg <= cfg_wr_data;
            end
            walk_reg  <= walk_next;
            fresh_reg <= fresh_next;
            seen_reg  <= seen_next;
        end
    end

    // node table
    always_ff @(posedge clk)
    begin
        if (cmd.label_wr)
        begin
            label_mem[node[IDX_W-1:0]] <= label;
        end
        if (cmd.label_rd)
        begin
            label_q <= label_mem[walk_reg[IDX_W-1:0]];
        end
    end

    // rename table
    always_ff @(posedge clk)
    begin
        if (cmd.map_miss)
        begin
            map_mem[label_q] <= fresh_reg;
        end
        if (cmd.map_rd)
        begin
            map_q <= map_mem[label_q];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.map_miss)
        begin
            out_label_reg <= fresh_reg;
        end
        else if (cmd.out_load_map)
        begin
            out_label_reg <= map_q;
        end
    end

    assign status.assign_ok  = ({1'b0, node} < eff_count);
    assign status.count_zero = (eff_count == '0);
    assign status.hit        = seen_reg[label_q];
    assign status.last       = (({1'b0, walk_reg} + COUNT_W'(1)) == eff_count);

    assign out_node  = walk_reg;
    assign new_label = out_label_reg;

endmodule

>>> hw/rtl/glt_ctrl.sv
`timescale 1ns / 1ps

module glt_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  mode,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  glt_pkg::glt_status_t  status,
    output glt_pkg::glt_cmd_t     cmd
);
    import glt_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_RD_LABEL = 3'd1;
    localparam logic [2:0] S_CHECK    = 3'd2;
    localparam logic [2:0] S_MAP      = 3'd3;
    localparam logic [2:0] S_EMIT     = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       in_fire;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_EMIT);
    assign in_fire   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (mode == MODE_ASSIGN)
                    begin
                        cmd.label_wr = status.assign_ok;
                    end
                    else if (!status.count_zero)
                    begin
                        cmd.start  = 1'b1;
                        state_next = S_RD_LABEL;
                    end
                end
            end
            S_RD_LABEL:
            begin
                cmd.label_rd = 1'b1;
                state_next   = S_CHECK;
            end
            S_CHECK:
            begin
                if (status.hit)
                begin
                    cmd.map_rd = 1'b1;
                    state_next = S_MAP;
                end
                else
                begin
                    cmd.map_miss = 1'b1;
                    state_next   = S_EMIT;
                end
            end
            S_MAP:
            begin
                cmd.out_load_map = 1'b1;
                state_next       = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_ready)
                begin
                    if (status.last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.walk_inc = 1'b1;
                        state_next   = S_RD_LABEL;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
